FILE: sv/keyboard_key_buffer_device_assert.svh
// assertion macros for the keyboard key buffer device
// used by the top level only, expects clk and rst_n in scope
`ifndef KEYBOARD_KEY_BUFFER_DEVICE_ASSERT_SVH
`define KEYBOARD_KEY_BUFFER_DEVICE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define KKB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define KKB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/kkb_pkg.sv
// shared types, codes and key classification for the keyboard key buffer
// no dependencies
package kkb_pkg;

    localparam int FIFO_DEPTH_DEF = 16;
    localparam int KEY_SPACE      = 256;

    localparam logic [15:0] KEY_LO = 16'h0020;
    localparam logic [15:0] KEY_HI = 16'h007f;

    localparam logic [15:0] KEY_BKSP  = 16'h0010;
    localparam logic [15:0] KEY_ENTER = 16'h0011;
    localparam logic [15:0] KEY_INS   = 16'h0012;
    localparam logic [15:0] KEY_DEL   = 16'h0013;
    localparam logic [15:0] KEY_UP    = 16'h0080;
    localparam logic [15:0] KEY_DOWN  = 16'h0081;
    localparam logic [15:0] KEY_LEFT  = 16'h0082;
    localparam logic [15:0] KEY_RIGHT = 16'h0083;
    localparam logic [15:0] KEY_SHFT  = 16'h0090;
    localparam logic [15:0] KEY_CTRL  = 16'h0091;

    localparam logic [1:0] REQ_CPU     = 2'd0;
    localparam logic [1:0] REQ_PRESS   = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;

    localparam logic [15:0] CMD_CLEAR = 16'd0;
    localparam logic [15:0] CMD_POP   = 16'd1;
    localparam logic [15:0] CMD_HELD  = 16'd2;
    localparam logic [15:0] CMD_MSG   = 16'd3;

    typedef enum logic [1:0] {
        KEY_INVALID   = 2'd0,
        KEY_SPECIAL   = 2'd1,
        KEY_PRINTABLE = 2'd2
    } key_class_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load_now;
        logic load_pop;
    } kkb_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic pop_read;
    } kkb_stat_t;

    function automatic key_class_t key_class(input logic [15:0] k);
        key_class_t cls;
        cls = KEY_INVALID;
        if (k >= KEY_LO && k <= KEY_HI)
        begin
            cls = KEY_PRINTABLE;
        end
        else
        begin
            case (k)
                KEY_BKSP, KEY_ENTER, KEY_INS, KEY_DEL,
                KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT,
                KEY_SHFT, KEY_CTRL: cls = KEY_SPECIAL;
                default: cls = KEY_INVALID;
            endcase
        end
        return cls;
    endfunction

endpackage

FILE: sv/kkb_ctrl.sv
// controller: input handshake, pop read wait state and output valid
// depends on kkb_pkg
module kkb_ctrl
    import kkb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  kkb_stat_t stat,
    output kkb_ctrl_t ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_POP  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
        ctrl.accept   = in_valid && in_ready;
        ctrl.load_now = ctrl.accept && !stat.pop_read;
        ctrl.load_pop = (state_reg == ST_POP);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.accept && stat.pop_read)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (ctrl.load_now || ctrl.load_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: sv/kkb_datapath.sv
// datapath: key fifo memory, pointers, held-key bitmap, message and result registers
// depends on kkb_pkg
module kkb_datapath
    import kkb_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  kkb_ctrl_t   ctrl,
    output kkb_stat_t   stat,
    input  logic [1:0]  req_type,
    input  logic [15:0] command,
    input  logic [15:0] operand_b,
    output logic        c_write,
    output logic [15:0] c_value,
    output logic        irq_raise,
    output logic [15:0] irq_message,
    output logic        key_dropped
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = CW + 1;

    logic [7:0]    mem [0:FIFO_DEPTH-1];
    logic [7:0]    rd_data_reg;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [15:0]   msg_reg, msg_next;
    logic [KEY_SPACE-1:0] held_reg, held_next;

    logic          c_write_reg, irq_raise_reg, key_dropped_reg;
    logic [15:0]   c_value_reg, irq_message_reg;

    key_class_t    cls;
    logic          is_cpu, is_press, is_release, key_ok;
    logic          fifo_empty, fifo_full;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail, head_inc;
    logic          wr_en;
    logic          held_bit;
    logic          irq_hit;

    always_comb
    begin
        cls        = key_class(operand_b);
        key_ok     = (cls != KEY_INVALID);
        is_cpu     = (req_type == REQ_CPU);
        is_press   = (req_type == REQ_PRESS);
        is_release = (req_type == REQ_RELEASE);
        fifo_empty = (count_reg == '0);
        fifo_full  = !(count_reg < CW'(FIFO_DEPTH));

        // head + count stays below twice the depth, one subtract wraps it
        tail_sum = SW'(head_reg) + SW'(count_reg);
        if (tail_sum >= SW'(FIFO_DEPTH))
        begin
            tail_sum = tail_sum - SW'(FIFO_DEPTH);
        end
        tail = tail_sum[AW-1:0];

        if (head_reg == AW'(FIFO_DEPTH - 1))
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = head_reg + AW'(1);
        end

        held_bit = (operand_b[15:8] == 8'h00) && held_reg[operand_b[7:0]];
        irq_hit  = key_ok && (msg_reg != 16'h0000) &&
                   ((is_press && cls == KEY_SPECIAL) || is_release);

        stat.pop_read = is_cpu && (command == CMD_POP) && !fifo_empty;
        wr_en         = ctrl.accept && is_press && key_ok && !fifo_full;
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        msg_next   = msg_reg;
        held_next  = held_reg;
        if (ctrl.accept)
        begin
            case (req_type)
                REQ_CPU:
                begin
                    case (command)
                        CMD_CLEAR: count_next = '0;
                        CMD_POP:
                        begin
                            if (!fifo_empty)
                            begin
                                head_next  = head_inc;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        CMD_MSG: msg_next = operand_b;
                        default: ;
                    endcase
                end
                REQ_PRESS:
                begin
                    if (key_ok)
                    begin
                        held_next[operand_b[7:0]] = 1'b1;
                        if (!fifo_full)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
                REQ_RELEASE:
                begin
                    if (key_ok)
                    begin
                        held_next[operand_b[7:0]] = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            msg_reg   <= '0;
            held_reg  <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            msg_reg   <= msg_next;
            held_reg  <= held_next;
        end
    end

    // key fifo, read port always follows the head
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail] <= operand_b[7:0];
        end
        rd_data_reg <= mem[head_reg];
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctrl.load_pop)
        begin
            c_write_reg     <= 1'b1;
            c_value_reg     <= {8'h00, rd_data_reg};
            irq_raise_reg   <= 1'b0;
            irq_message_reg <= '0;
            key_dropped_reg <= 1'b0;
        end
        else if (ctrl.load_now)
        begin
            c_write_reg     <= is_cpu && (command == CMD_POP || command == CMD_HELD);
            c_value_reg     <= (is_cpu && command == CMD_HELD) ? {15'h0000, held_bit} : '0;
            irq_raise_reg   <= irq_hit;
            irq_message_reg <= irq_hit ? msg_reg : '0;
            key_dropped_reg <= is_press && key_ok && fifo_full;
        end
    end

    assign c_write     = c_write_reg;
    assign c_value     = c_value_reg;
    assign irq_raise   = irq_raise_reg;
    assign irq_message = irq_message_reg;
    assign key_dropped = key_dropped_reg;

endmodule

FILE: sv/keyboard_key_buffer_device.sv
// top level of the keyboard key buffer device: controller plus datapath
// depends on kkb_pkg, kkb_ctrl, kkb_datapath and keyboard_key_buffer_device_assert.svh
//
// usage:
//   input channel (in_valid/in_ready) carries one request per item: a cpu
//   command (req_type 0, command and operand_b as the A and B registers), a
//   host key press (1) or a host key release (2); operand_b is the key code.
//   output channel (out_valid/out_ready) returns exactly one result item per
//   request: c write and value, interrupt raise and message, key dropped flag.
//   out_valid rises in the cycle after accept, except for a pop from a
//   non-empty fifo, which first waits in ST_POP on the registered fifo read.
//   throughput: one item per cycle unless stalled by out_ready or by ST_POP.
//   in_ready is high while the controller is idle and the result register is
//   empty or being taken in that cycle; a stalled receiver therefore holds
//   at most one finished result and stops further input.
//   reset clears fifo pointers, the held-key bitmap, the interrupt message and
//   the output valid; fifo contents are not cleared and are never read unwritten.
module keyboard_key_buffer_device
    import kkb_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] command,
    input  logic [15:0] operand_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        c_write,
    output logic [15:0] c_value,
    output logic        irq_raise,
    output logic [15:0] irq_message,
    output logic        key_dropped
);

    `include "keyboard_key_buffer_device_assert.svh"

    kkb_ctrl_t ctrl_cmd;
    kkb_stat_t dp_stat;

    kkb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (dp_stat),
        .ctrl      (ctrl_cmd)
    );

    kkb_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl_cmd),
        .stat        (dp_stat),
        .req_type    (req_type),
        .command     (command),
        .operand_b   (operand_b),
        .c_write     (c_write),
        .c_value     (c_value),
        .irq_raise   (irq_raise),
        .irq_message (irq_message),
        .key_dropped (key_dropped)
    );

    // an item is only taken when the result register can accept its result
    `KKB_ASSERT_IMP(a_accept_room, in_valid && in_ready, !out_valid || out_ready, "busy accept")
    // the pop result lands in an empty result register
    `KKB_ASSERT_IMP(a_pop_room, ctrl_cmd.load_pop, !out_valid, "pop result overwrote result")
    // after the fifo read wait the pop result is offered
    `KKB_ASSERT_NXT(a_pop_result, ctrl_cmd.load_pop, out_valid && c_write, "pop result missing")
    // message is zero when no interrupt is raised
    `KKB_ASSERT_IMP(a_msg_zero, out_valid && !irq_raise, irq_message == 16'h0000, "stray message")

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for keyboard_key_buffer_device: directed and random traffic,
// every result checked against an in-bench model of the key fifo, bitmap and message
// depends on kkb_pkg and the keyboard_key_buffer_device rtl
module tb_top;
    import kkb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH        = FIFO_DEPTH_DEF;
    localparam int          HOLD_CYCLES  = 40;
    localparam int          DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam logic [1:0]  REQ_UNUSED   = 2'd3;

    typedef struct packed {
        logic        c_write;
        logic [15:0] c_value;
        logic        irq_raise;
        logic [15:0] irq_message;
        logic        key_dropped;
    } kb_result_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type    = REQ_CPU;
    logic [15:0] command     = CMD_CLEAR;
    logic [15:0] operand_b   = 16'h0000;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic        c_write;
    logic [15:0] c_value;
    logic        irq_raise;
    logic [15:0] irq_message;
    logic        key_dropped;

    // model state
    logic [7:0]  typed_keys [DEPTH];
    int          oldest_slot;
    int          queued_keys;
    logic        held_map [KEY_SPACE];
    logic [15:0] irq_msg;

    kb_result_t  pending_results [$];
    kb_result_t  next_result;

    bit          gaps_on       = 1'b1;
    int          hold_requests = 0;
    int          holds_done    = 0;
    int unsigned hold_left     = 0;
    int unsigned stall_left    = 0;
    int unsigned cycle_count   = 0;

    int unsigned items_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned drops_seen     = 0;
    int unsigned irqs_seen      = 0;
    int unsigned keys_popped    = 0;

    keyboard_key_buffer_device dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .command     (command),
        .operand_b   (operand_b),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .c_write     (c_write),
        .c_value     (c_value),
        .irq_raise   (irq_raise),
        .irq_message (irq_message),
        .key_dropped (key_dropped)
    );

    always #4 clk = ~clk;

    // printable range or one of the ten control/arrow/modifier codes
    function automatic key_class_t classify_key(input logic [15:0] code);
        key_class_t cls;
        cls = KEY_INVALID;
        if (code >= KEY_LO && code <= KEY_HI)
        begin
            cls = KEY_PRINTABLE;
        end
        else if (code[15:8] == 8'h00 &&
                 (code[7:2] == 6'b000100 || code[7:2] == 6'b100000 ||
                  code[7:1] == 7'b1001000))
        begin
            cls = KEY_SPECIAL;
        end
        return cls;
    endfunction

    function automatic kb_result_t keyboard_response(input logic [1:0]  req,
                                                     input logic [15:0] cmd,
                                                     input logic [15:0] b);
        kb_result_t r;
        key_class_t cls;
        r   = '0;
        cls = classify_key(b);
        case (req)
            REQ_CPU:
            begin
                case (cmd)
                    CMD_CLEAR: queued_keys = 0;
                    CMD_POP:
                    begin
                        r.c_write = 1'b1;
                        if (queued_keys != 0)
                        begin
                            r.c_value   = {8'h00, typed_keys[oldest_slot]};
                            oldest_slot = (oldest_slot + 1) % DEPTH;
                            queued_keys = queued_keys - 1;
                        end
                    end
                    CMD_HELD:
                    begin
                        r.c_write = 1'b1;
                        r.c_value = {15'd0, (b[15:8] == 8'h00) && held_map[b[7:0]]};
                    end
                    CMD_MSG: irq_msg = b;
                    default: ;
                endcase
            end
            REQ_PRESS:
            begin
                if (cls != KEY_INVALID)
                begin
                    held_map[b[7:0]] = 1'b1;
                    if (queued_keys < DEPTH)
                    begin
                        typed_keys[(oldest_slot + queued_keys) % DEPTH] = b[7:0];
                        queued_keys = queued_keys + 1;
                    end
                    else
                    begin
                        r.key_dropped = 1'b1;
                    end
                    // printable presses never interrupt
                    if (cls == KEY_SPECIAL && irq_msg != 16'h0000)
                    begin
                        r.irq_raise   = 1'b1;
                        r.irq_message = irq_msg;
                    end
                end
            end
            REQ_RELEASE:
            begin
                if (cls != KEY_INVALID)
                begin
                    held_map[b[7:0]] = 1'b0;
                    if (irq_msg != 16'h0000)
                    begin
                        r.irq_raise   = 1'b1;
                        r.irq_message = irq_msg;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int field_differs(input string field, input logic [15:0] want,
                                         input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            return 1;
        end
        return 0;
    endfunction

    // predict on accept, check on every taken result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                next_result = keyboard_response(req_type, command, operand_b);
                pending_results.insert(pending_results.size(), next_result);
                drops_seen  += next_result.key_dropped;
                irqs_seen   += next_result.irq_raise;
                keys_popped += (req_type == REQ_CPU && command == CMD_POP &&
                                next_result.c_value != 16'h0000);
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with no item pending", $time);
                    mismatches++;
                end
                else
                begin
                    next_result = pending_results[0];
                    pending_results.delete(0);
                    mismatches += field_differs("c_write", {15'd0, next_result.c_write},
                                                {15'd0, c_write});
                    mismatches += field_differs("c_value", next_result.c_value, c_value);
                    mismatches += field_differs("irq_raise", {15'd0, next_result.irq_raise},
                                                {15'd0, irq_raise});
                    mismatches += field_differs("irq_message", next_result.irq_message,
                                                irq_message);
                    mismatches += field_differs("key_dropped",
                                                {15'd0, next_result.key_dropped},
                                                {15'd0, key_dropped});
                end
            end
        end
    end

    // receiver: long hold on request, else random short stalls
    always @(posedge clk)
    begin
        if (holds_done != hold_requests)
        begin
            holds_done <= hold_requests;
            hold_left  <= HOLD_CYCLES - 1;
            out_ready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results pending", $time, pending_results.size());
            $display("** keyboard_key_buffer_device: FAILED **");
            $finish;
        end
    end

    // call at a rising edge; returns at the edge where the item is taken
    task automatic send_item(input logic [1:0] req, input logic [15:0] cmd,
                             input logic [15:0] b);
        int unsigned gap;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        command   <= cmd;
        operand_b <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    function automatic logic [15:0] special_key(input int unsigned idx);
        case (idx)
            0:       return KEY_BKSP;
            1:       return KEY_ENTER;
            2:       return KEY_INS;
            3:       return KEY_DEL;
            4:       return KEY_UP;
            5:       return KEY_DOWN;
            6:       return KEY_LEFT;
            7:       return KEY_RIGHT;
            8:       return KEY_SHFT;
            default: return KEY_CTRL;
        endcase
    endfunction

    function automatic logic [15:0] any_valid_key();
        if ($urandom_range(0, 9) < 7)
            return 16'($urandom_range(KEY_LO, KEY_HI));
        return special_key($urandom_range(0, 9));
    endfunction

    task automatic test_idle_device();
        send_item(REQ_RELEASE, CMD_CLEAR, 16'h0041);   // messages off: no interrupt
        send_item(REQ_CPU, CMD_POP, 16'h0000);         // empty pop gives zero
        send_item(REQ_CPU, CMD_HELD, 16'h0041);
    endtask

    task automatic test_fifo_overflow();
        int unsigned k;
        send_item(REQ_CPU, CMD_MSG, 16'hffff);
        send_item(REQ_PRESS, 16'h0000, KEY_LO);
        send_item(REQ_PRESS, 16'hffff, KEY_HI);
        for (k = 0; k < 10; k++)
            send_item(REQ_PRESS, CMD_POP, special_key(k));
        for (k = 0; k < 4; k++)
            send_item(REQ_PRESS, CMD_MSG, 16'h0061 + 16'(k));
        send_item(REQ_PRESS, CMD_HELD, KEY_SHFT);      // fifo full: dropped, still interrupts
        send_item(REQ_CPU, CMD_HELD, KEY_SHFT);
        send_item(REQ_CPU, CMD_POP, 16'hffff);
    endtask

    task automatic test_odd_requests();
        send_item(REQ_CPU, CMD_HELD, 16'hffff);        // key code out of range
        send_item(REQ_CPU, 16'hffff, 16'hffff);        // unknown command
        send_item(REQ_UNUSED, 16'hffff, 16'hffff);     // unknown request type
        send_item(REQ_PRESS, 16'h0000, 16'hffff);      // invalid key
        send_item(REQ_RELEASE, 16'h0000, 16'h0000);
        send_item(REQ_RELEASE, 16'h0000, KEY_SHFT);
        send_item(REQ_CPU, CMD_CLEAR, 16'h1234);
        send_item(REQ_CPU, CMD_POP, 16'h0000);
    endtask

    task automatic test_random_traffic(input int unsigned count);
        int unsigned i;
        int unsigned pick;
        int unsigned press_pct;
        int unsigned pop_pct;
        logic [15:0] b;
        press_pct = 40;
        pop_pct   = 20;
        for (i = 0; i < count; i++)
        begin
            // every 60 items pick filling or draining at random so the fifo hits both ends
            if (i % 60 == 0)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    press_pct = 50;
                    pop_pct   = 10;
                end
                else
                begin
                    press_pct = 20;
                    pop_pct   = 40;
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < press_pct)
                send_item(REQ_PRESS, 16'($urandom), any_valid_key());
            else if (pick < press_pct + 15)
                send_item(REQ_RELEASE, 16'($urandom), any_valid_key());
            else if (pick < press_pct + 15 + pop_pct)
                send_item(REQ_CPU, CMD_POP, 16'($urandom));
            else if (pick < 88)
            begin
                b = ($urandom_range(0, 3) == 0) ? 16'($urandom) : any_valid_key();
                send_item(REQ_CPU, CMD_HELD, b);
            end
            else if (pick < 90)
                send_item(REQ_CPU, CMD_CLEAR, 16'($urandom));
            else if (pick < 93)
            begin
                b = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
                send_item(REQ_CPU, CMD_MSG, b);
            end
            else if (pick < 95)
                send_item(REQ_CPU, 16'($urandom_range(4, 16'hffff)), 16'($urandom));
            else if (pick < 97)
                send_item(REQ_UNUSED, 16'($urandom), 16'($urandom));
            else
                send_item(($urandom_range(0, 1) == 1) ? REQ_PRESS : REQ_RELEASE,
                          16'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_backpressure();
        hold_requests <= hold_requests + 1;
        test_random_traffic(24);
    endtask

    task automatic test_full_rate();
        gaps_on = 1'b0;
        test_random_traffic(150);
    endtask

    initial
    begin
        oldest_slot = 0;
        queued_keys = 0;
        irq_msg     = 16'h0000;
        for (int k = 0; k < KEY_SPACE; k++)
            held_map[k] = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_device();
        test_fifo_overflow();
        test_odd_requests();
        test_random_traffic(820);
        test_backpressure();
        test_full_rate();
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d items, checked %0d results, %0d mismatches",
                 items_sent, results_seen, mismatches);
        $display("fifo overflows %0d, interrupts %0d, keys popped %0d",
                 drops_seen, irqs_seen, keys_popped);
        if (mismatches == 0)
            $display("** keyboard_key_buffer_device: PASSED **");
        else
            $display("** keyboard_key_buffer_device: FAILED **");
        $finish;
    end

endmodule
